@@ src/tetrahedral_bounds_builder_macros.svh @@
// Assertion macros used by the checker of this block.
// Both sample on the rising edge of clock and are switched off while reset is high.
`ifndef TETRAHEDRAL_BOUNDS_BUILDER_MACROS_SVH
`define TETRAHEDRAL_BOUNDS_BUILDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBB_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tetrahedral bounds builder: port check failed");

// The consequent must hold in the cycle after the antecedent.
`define TBB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tetrahedral bounds builder: port check failed");

`endif

@@ src/tbb_pkg.sv @@
`default_nettype none

package tbb_pkg;

   localparam int COORD_W    = 24;
   localparam int SUM_W      = COORD_W + 1;
   localparam int INV_W      = 17;
   localparam int FRAC_SHIFT = 16;
   localparam int PROD_W     = COORD_W + INV_W + 1;
   localparam int BOUND_W    = COORD_W + 2;
   localparam int OUT_W      = 26;
   localparam int AXES       = 4;

   localparam int REQ_DATA_W = ((3 * COORD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * AXES * OUT_W + 7) / 8) * 8;
   localparam int CSR_IDX_W  = 2;

   // 1/sqrt(2) in Q0.16, held with a clear sign bit so that it multiplies as signed.
   localparam logic signed [INV_W:0] INV_SQRT2_Q16 = 18'sd46341;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [BOUND_W-1:0] bound_type;
   typedef logic signed [OUT_W-1:0]   out_type;
   typedef bound_type                 proj_type [AXES];

   typedef struct packed {
      logic valid;
      logic last;
   } ctl_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_X = 2'd0,
      CSR_OFFSET_Y = 2'd1,
      CSR_OFFSET_Z = 2'd2
   } csr_index_type;

endpackage

`default_nettype wire

@@ src/tbb_proj.sv @@
`default_nettype none

module tbb_proj (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire tbb_pkg::ctl_type   in_ctl,
   input  wire tbb_pkg::coord_type point_x,
   input  wire tbb_pkg::coord_type point_y,
   input  wire tbb_pkg::coord_type point_z,
   input  wire tbb_pkg::coord_type offset_x,
   input  wire tbb_pkg::coord_type offset_y,
   input  wire tbb_pkg::coord_type offset_z,
   output tbb_pkg::ctl_type        proj_ctl,
   output tbb_pkg::proj_type       proj
);

   tbb_pkg::ctl_type   pt_ctl_ff, sum_ctl_ff, proj_ctl_ff;
   tbb_pkg::coord_type pt_x_ff, pt_y_ff, pt_z_ff;
   tbb_pkg::coord_type sum_x_ff, sum_y_ff, sum_z_ff;
   tbb_pkg::coord_type sum_x_in, sum_y_in, sum_z_in;
   logic signed [tbb_pkg::PROD_W-1:0] prod_z;
   tbb_pkg::bound_type zs, x_ext, y_ext;
   tbb_pkg::proj_type  proj_ff, proj_in;

   function automatic tbb_pkg::coord_type sat_add(tbb_pkg::coord_type a,
                                                  tbb_pkg::coord_type b);
      logic signed [tbb_pkg::SUM_W-1:0] s;
      tbb_pkg::coord_type r;
      s = tbb_pkg::SUM_W'(a) + tbb_pkg::SUM_W'(b);
      if (s[tbb_pkg::COORD_W] != s[tbb_pkg::COORD_W-1]) begin
         r = {s[tbb_pkg::COORD_W], {(tbb_pkg::COORD_W-1){~s[tbb_pkg::COORD_W]}}};
      end else begin
         r = s[tbb_pkg::COORD_W-1:0];
      end
      return r;
   endfunction

   always_comb begin
      sum_x_in = sat_add(pt_x_ff, offset_x);
      sum_y_in = sat_add(pt_y_ff, offset_y);
      sum_z_in = sat_add(pt_z_ff, offset_z);
   end

   // The arithmetic shift floors the scaled z towards minus infinity.
   always_comb begin
      prod_z     = tbb_pkg::PROD_W'(sum_z_ff) * tbb_pkg::PROD_W'(tbb_pkg::INV_SQRT2_Q16);
      zs         = tbb_pkg::BOUND_W'(prod_z >>> tbb_pkg::FRAC_SHIFT);
      x_ext      = tbb_pkg::BOUND_W'(sum_x_ff);
      y_ext      = tbb_pkg::BOUND_W'(sum_y_ff);
      proj_in[0] = -x_ext - zs;
      proj_in[1] = x_ext - zs;
      proj_in[2] = zs - y_ext;
      proj_in[3] = y_ext + zs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_ctl_ff   <= '0;
         sum_ctl_ff  <= '0;
         proj_ctl_ff <= '0;
      end else if (advance) begin
         pt_ctl_ff   <= in_ctl;
         sum_ctl_ff  <= pt_ctl_ff;
         proj_ctl_ff <= sum_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pt_x_ff  <= point_x;
         pt_y_ff  <= point_y;
         pt_z_ff  <= point_z;
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         sum_z_ff <= sum_z_in;
         proj_ff  <= proj_in;
      end
   end

   assign proj_ctl = proj_ctl_ff;
   assign proj     = proj_ff;

endmodule

`default_nettype wire

@@ src/tetrahedral_bounds_builder.sv @@
// Tetrahedral bounds builder: gathers the four-axis bounding volume of one object.
// The req_ channel carries one mesh point per item; req_tlast marks the last point.
// Each point has the object position added (saturating), is projected onto the four
// tetrahedral axes and widens the running minimum and maximum of each axis.
// On the last point the rsp_ channel carries the eight bounds as one item and the
// next point starts a new object.
// The csr_ channel writes the object position (index 0 x, 1 y, 2 z); it is always
// ready, and other indexes are ignored. Write it only between objects.
// Throughput is one point per cycle while req_tready is high. A last point passes in
// turn through the input register, the position add, the projection with the 1/sqrt2
// multiply and the bound update into the result register, where its result is shown.
// If the receiver stalls, points keep flowing until a further last point reaches
// the bound stage; only then is req_tready dropped until the held result is taken.
// Reset clears the position registers, empties the pipeline and the result
// register, and marks the next point as the first of an object.
`default_nettype none

module tetrahedral_bounds_builder (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // point_x, point_y, point_z
   input  wire logic [tbb_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic                              req_tlast,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // min_a, min_b, min_c, min_d, max_a, max_b, max_c, max_d
   output logic [tbb_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [tbb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [tbb_pkg::COORD_W-1:0]       csr_data
);

   tbb_pkg::coord_type offset_x_ff, offset_y_ff, offset_z_ff;
   tbb_pkg::ctl_type   in_ctl, proj_ctl;
   tbb_pkg::proj_type  proj;
   tbb_pkg::proj_type  low_ff, high_ff, low_in, high_in;
   logic               awaiting_first_ff, awaiting_first_in;
   logic               advance, emit;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [tbb_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         offset_z_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            tbb_pkg::CSR_OFFSET_X: offset_x_ff <= csr_data;
            tbb_pkg::CSR_OFFSET_Y: offset_y_ff <= csr_data;
            tbb_pkg::CSR_OFFSET_Z: offset_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Only a last point meeting an occupied, untaken result register holds things up.
   assign advance    = !(proj_ctl.valid && proj_ctl.last && rsp_valid_ff && !rsp_tready);
   assign req_tready = advance;
   assign emit       = advance && proj_ctl.valid && proj_ctl.last;

   assign in_ctl.valid = req_tvalid && advance;
   assign in_ctl.last  = req_tlast;

   tbb_proj u_proj (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_ctl   (in_ctl),
      .point_x  (req_tdata[0 +: tbb_pkg::COORD_W]),
      .point_y  (req_tdata[tbb_pkg::COORD_W +: tbb_pkg::COORD_W]),
      .point_z  (req_tdata[2*tbb_pkg::COORD_W +: tbb_pkg::COORD_W]),
      .offset_x (offset_x_ff),
      .offset_y (offset_y_ff),
      .offset_z (offset_z_ff),
      .proj_ctl (proj_ctl),
      .proj     (proj)
   );

   always_comb begin
      low_in            = low_ff;
      high_in           = high_ff;
      awaiting_first_in = awaiting_first_ff;
      if (advance && proj_ctl.valid) begin
         for (int i = 0; i < tbb_pkg::AXES; i++) begin
            if (awaiting_first_ff || (proj[i] < low_ff[i])) begin
               low_in[i] = proj[i];
            end
            if (awaiting_first_ff || (proj[i] > high_ff[i])) begin
               high_in[i] = proj[i];
            end
         end
         awaiting_first_in = proj_ctl.last;
      end
   end

   always_comb begin
      rsp_data_in = '0;
      for (int i = 0; i < tbb_pkg::AXES; i++) begin
         rsp_data_in[i*tbb_pkg::OUT_W +: tbb_pkg::OUT_W] = tbb_pkg::OUT_W'(low_in[i]);
         rsp_data_in[(tbb_pkg::AXES+i)*tbb_pkg::OUT_W +: tbb_pkg::OUT_W] =
            tbb_pkg::OUT_W'(high_in[i]);
      end
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_first_ff <= 1'b1;
         rsp_valid_ff      <= 1'b0;
      end else begin
         awaiting_first_ff <= awaiting_first_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff  <= low_in;
      high_ff <= high_in;
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

@@ src/tbb_checker.sv @@
`default_nettype none
`include "tetrahedral_bounds_builder_macros.svh"

module tbb_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic [tbb_pkg::REQ_DATA_W-1:0] req_tdata,
   input wire logic                           req_tlast,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic [tbb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic                           csr_valid,
   input wire logic                           csr_ready,
   input wire logic [tbb_pkg::CSR_IDX_W-1:0]  csr_index,
   input wire logic [tbb_pkg::COORD_W-1:0]    csr_data
);

   // A held result keeps its place and its bounds until the receiver takes it.
   `TBB_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `TBB_ASSERT_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))

   // Points are refused only while a result waits on a stalled receiver.
   `TBB_ASSERT_NOW(a_stall_cause, !req_tready, rsp_tvalid && !rsp_tready)

   // The position registers never push back.
   `TBB_ASSERT_NOW(a_csr_ready, csr_valid, csr_ready)

endmodule

bind tetrahedral_bounds_builder tbb_checker u_tbb_checker (.*);

`default_nettype wire
